// ===== hw/rtl/rwsp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE stream parser.
// No dependencies; imported by every module of the block.
package rwsp_pkg;

    // chunk and header tags, first byte in the high lane
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // fmt chunk layout
    localparam logic [32:0] FMT_MIN_SIZE    = 33'd16;
    localparam logic [4:0]  FMT_BITS_OFFSET = 5'd14;
    localparam logic [4:0]  FMT_OFFSET_SAT  = 5'd16;

    // header walk
    localparam logic [3:0] HDR_RIFF_LAST = 4'd3;
    localparam logic [3:0] HDR_WAVE_LAST = 4'd11;
    localparam logic [3:0] CHUNK_TAG_END = 4'd4;
    localparam logic [3:0] CHUNK_HDR_END = 4'd7;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CHUNK  = 3'd1,
        PH_FMT    = 3'd2,
        PH_DATA   = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_WAVE    = 3'd1,
        ST_FMT_SHORT   = 3'd2,
        ST_FMT_TRUNC   = 3'd3,
        ST_DATA_TRUNC  = 3'd4,
        ST_MISSING     = 3'd5,
        ST_ZERO_FIELD  = 3'd6
    } status_t;

    typedef enum logic {
        KIND_PCM    = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    // one result item
    typedef struct packed {
        logic        kind;
        logic [7:0]  pcm_byte;
        logic [2:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic        last;
    } result_t;

    // what one parsed byte produces: an optional pcm item, an optional status item
    typedef struct packed {
        logic        pcm_en;
        logic        stat_en;
        logic [7:0]  pcm_byte;
        logic [2:0]  status;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
    } emit_t;

endpackage

// ===== hw/rtl/rwsp_parser.sv =====
// Input register and per-byte parse logic of the RIFF/WAVE stream parser.
// Depends on rwsp_pkg; feeds rwsp_out_queue through an emit_t bundle.
module rwsp_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [7:0]         file_byte,
    input  logic               end_of_file,
    input  logic               room,
    output rwsp_pkg::emit_t    emit
);
    import rwsp_pkg::*;

    // input register
    logic        full_reg,  full_next;
    logic [7:0]  byte_reg;
    logic        eof_reg;
    logic        fire;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [3:0]  idx_reg,   idx_next;
    logic [31:0] tag_reg,   tag_next;
    logic [32:0] rem_reg,   rem_next;
    logic [4:0]  off_reg,   off_next;
    logic [15:0] ftag_reg,  ftag_next;
    logic [15:0] chan_reg,  chan_next;
    logic [31:0] rate_reg,  rate_next;
    logic [15:0] bits_reg,  bits_next;
    logic        seen_reg,  seen_next;

    // step decisions
    logic        pcm_en;
    logic        stat_en;
    status_t     stat_code;
    logic [31:0] tag_shift;
    logic [32:0] rem_dec;
    logic [32:0] rem_hdr;
    logic [32:0] rem_pad;
    status_t     chk_code;

    assign fire       = full_reg & room;
    assign item_ready = ~full_reg | room;

    // input register load and drain
    always_comb
    begin
        full_next = full_reg;
        if (item_valid && item_ready)
        begin
            full_next = 1'b1;
        end
        else if (fire)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            byte_reg <= file_byte;
            eof_reg  <= end_of_file;
        end
    end

    // shared terms of the step
    assign tag_shift = {tag_reg[23:0], byte_reg};
    assign rem_dec   = rem_reg - 33'd1;
    assign rem_pad   = rem_hdr + {32'd0, rem_hdr[0]};

    always_comb
    begin
        if (!seen_reg)
        begin
            chk_code = ST_MISSING;
        end
        else if (chan_reg == 16'd0 || rate_reg == 32'd0)
        begin
            chk_code = ST_ZERO_FIELD;
        end
        else
        begin
            chk_code = ST_OK;
        end
    end

    // size bytes arrive little-endian
    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    rem_hdr = rem_reg | {25'd0, byte_reg};
            2'd1:    rem_hdr = rem_reg | {17'd0, byte_reg, 8'd0};
            2'd2:    rem_hdr = rem_reg | {9'd0, byte_reg, 16'd0};
            2'd3:    rem_hdr = rem_reg | {1'b0, byte_reg, 24'd0};
            default: rem_hdr = rem_reg;
        endcase
    end

    // next state of the parse for the byte in the input register
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        off_next   = off_reg;
        ftag_next  = ftag_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        seen_next  = seen_reg;
        pcm_en     = 1'b0;
        stat_en    = 1'b0;
        stat_code  = ST_OK;

        case (phase_reg)
            PH_HEADER:
            begin
                tag_next = tag_shift;
                if (idx_reg == HDR_RIFF_LAST && tag_shift != TAG_RIFF)
                begin
                    stat_en    = 1'b1;
                    stat_code  = ST_NOT_WAVE;
                    phase_next = PH_DONE;
                end
                else if (idx_reg == HDR_WAVE_LAST)
                begin
                    if (tag_shift != TAG_WAVE)
                    begin
                        stat_en    = 1'b1;
                        stat_code  = ST_NOT_WAVE;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_CHUNK;
                        idx_next   = 4'd0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 4'd1;
                end
            end
            PH_CHUNK:
            begin
                if (idx_reg < CHUNK_TAG_END)
                begin
                    tag_next = tag_shift;
                    rem_next = (idx_reg == 4'd0) ? 33'd0 : rem_reg;
                    idx_next = idx_reg + 4'd1;
                end
                else
                begin
                    rem_next = rem_hdr;
                    if (idx_reg < CHUNK_HDR_END)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        idx_next = 4'd0;
                        if (tag_reg == TAG_FMT)
                        begin
                            if (rem_hdr < FMT_MIN_SIZE)
                            begin
                                stat_en    = 1'b1;
                                stat_code  = ST_FMT_SHORT;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                off_next   = 5'd0;
                                phase_next = PH_FMT;
                            end
                        end
                        else if (tag_reg == TAG_DATA)
                        begin
                            if (rem_hdr == 33'd0)
                            begin
                                stat_en    = 1'b1;
                                stat_code  = chk_code;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        else
                        begin
                            // other chunks are skipped with their pad byte
                            rem_next = rem_pad;
                            if (rem_pad != 33'd0)
                            begin
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
            end
            PH_FMT:
            begin
                case (off_reg)
                    5'd0: ftag_next[7:0]   = byte_reg;
                    5'd1: ftag_next[15:8]  = byte_reg;
                    5'd2: chan_next[7:0]   = byte_reg;
                    5'd3: chan_next[15:8]  = byte_reg;
                    5'd4: rate_next[7:0]   = byte_reg;
                    5'd5: rate_next[15:8]  = byte_reg;
                    5'd6: rate_next[23:16] = byte_reg;
                    5'd7: rate_next[31:24] = byte_reg;
                    FMT_BITS_OFFSET:        bits_next[7:0]  = byte_reg;
                    FMT_BITS_OFFSET + 5'd1: bits_next[15:8] = byte_reg;
                    default: ;
                endcase
                // offset saturates past the last field of interest
                if (off_reg != FMT_OFFSET_SAT)
                begin
                    off_next = off_reg + 5'd1;
                end
                rem_next = rem_dec;
                if (rem_dec == 33'd0)
                begin
                    seen_next  = 1'b1;
                    phase_next = PH_CHUNK;
                end
            end
            PH_DATA:
            begin
                pcm_en   = 1'b1;
                rem_next = rem_dec;
                if (rem_dec == 33'd0)
                begin
                    stat_en    = 1'b1;
                    stat_code  = chk_code;
                    phase_next = PH_DONE;
                end
            end
            PH_SKIP:
            begin
                rem_next = rem_dec;
                if (rem_dec == 33'd0)
                begin
                    phase_next = PH_CHUNK;
                end
            end
            default: ;
        endcase

        // end of file closes the parse and clears state for the next file
        if (eof_reg)
        begin
            case (phase_next)
                PH_HEADER:
                begin
                    stat_en   = 1'b1;
                    stat_code = ST_NOT_WAVE;
                end
                PH_FMT:
                begin
                    stat_en   = 1'b1;
                    stat_code = ST_FMT_TRUNC;
                end
                PH_DATA:
                begin
                    stat_en   = 1'b1;
                    stat_code = ST_DATA_TRUNC;
                end
                PH_CHUNK, PH_SKIP:
                begin
                    stat_en   = 1'b1;
                    stat_code = ST_MISSING;
                end
                default: ;
            endcase
            phase_next = PH_HEADER;
            idx_next   = 4'd0;
            tag_next   = 32'd0;
            rem_next   = 33'd0;
            off_next   = 5'd0;
            ftag_next  = 16'd0;
            chan_next  = 16'd0;
            rate_next  = 32'd0;
            bits_next  = 16'd0;
            seen_next  = 1'b0;
        end
    end

    // results of the step; fmt fields only on an ok status
    always_comb
    begin
        emit.pcm_en        = fire & pcm_en;
        emit.stat_en       = fire & stat_en;
        emit.pcm_byte      = byte_reg;
        emit.status        = stat_code;
        emit.audio_format  = (stat_code == ST_OK) ? ftag_reg : 16'd0;
        emit.channel_count = (stat_code == ST_OK) ? chan_reg : 16'd0;
        emit.rate_hz       = (stat_code == ST_OK) ? rate_reg : 32'd0;
        emit.sample_bits   = (stat_code == ST_OK) ? bits_reg : 16'd0;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            idx_reg   <= 4'd0;
            tag_reg   <= 32'd0;
            rem_reg   <= 33'd0;
            off_reg   <= 5'd0;
            ftag_reg  <= 16'd0;
            chan_reg  <= 16'd0;
            rate_reg  <= 32'd0;
            bits_reg  <= 16'd0;
            seen_reg  <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            off_reg   <= off_next;
            ftag_reg  <= ftag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ===== hw/rtl/rwsp_out_queue.sv =====
// Four-entry result queue: takes up to two items a cycle, gives one.
// Depends on rwsp_pkg for emit_t and result_t.
module rwsp_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  rwsp_pkg::emit_t    emit,
    output logic               room,
    output logic               result_valid,
    input  logic               result_ready,
    output rwsp_pkg::result_t  head
);
    import rwsp_pkg::*;

    result_t     q_reg [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  cnt_reg,    cnt_next;

    result_t     pcm_ent;
    result_t     stat_ent;
    result_t     d0;
    logic        we0;
    logic        we1;
    logic        pop;
    logic [2:0]  push_cnt;

    // item images built from the step results
    always_comb
    begin
        pcm_ent               = '0;
        pcm_ent.kind          = KIND_PCM;
        pcm_ent.pcm_byte      = emit.pcm_byte;

        stat_ent               = '0;
        stat_ent.kind          = KIND_STATUS;
        stat_ent.status        = emit.status;
        stat_ent.audio_format  = emit.audio_format;
        stat_ent.channel_count = emit.channel_count;
        stat_ent.rate_hz       = emit.rate_hz;
        stat_ent.sample_bits   = emit.sample_bits;
        stat_ent.last          = 1'b1;
    end

    // a pcm item goes first when both come from one byte
    assign we0      = emit.pcm_en | emit.stat_en;
    assign we1      = emit.pcm_en & emit.stat_en;
    assign d0       = emit.pcm_en ? pcm_ent : stat_ent;
    assign push_cnt = {2'b00, we0} + {2'b00, we1};

    assign room         = (cnt_reg <= 3'd2);
    assign result_valid = (cnt_reg != 3'd0);
    assign pop          = result_valid & result_ready;
    assign head         = q_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + {1'b0, we0} + {1'b0, we1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        cnt_next    = cnt_reg + push_cnt - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            q_reg[wr_ptr_reg] <= d0;
        end
        if (we1)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= stat_ent;
        end
    end

endmodule

// ===== hw/rtl/riff_wave_stream_parser_core.sv =====
// Top level of the RIFF/WAVE stream parser: input register, parse step, result queue.
// Depends on rwsp_pkg, rwsp_parser and rwsp_out_queue.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | item_valid / item_ready    | file_byte, end_of_file
//  result   | result_valid / result_ready| kind, pcm_byte, status, audio_format,
//           |                            | channel_count, rate_hz, sample_bits, last
//
// One byte is taken per cycle while item_ready is high; each byte is held in the input register,
// and its results are written into the result queue once it has room, and leave from there.
// A byte that ends the data chunk, or ends the file inside it, gives two results; the
// four-entry result queue absorbs the extra result and input keeps flowing.
// rst_n clears the parse state and empties the queue; no clearing pass is needed.
// When result_ready is low the queue fills and item_ready drops once the input register
// holds a byte and fewer than two queue entries are free.
module riff_wave_stream_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        kind,
    output logic [7:0]  pcm_byte,
    output logic [2:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channel_count,
    output logic [31:0] rate_hz,
    output logic [15:0] sample_bits,
    output logic        last
);
    import rwsp_pkg::*;

    emit_t   emit;
    logic    room;
    result_t head;

    // byte parse
    rwsp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .room        (room),
        .emit        (emit)
    );

    // result queue
    rwsp_out_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .head         (head)
    );

    // result fields
    assign kind          = head.kind;
    assign pcm_byte      = head.pcm_byte;
    assign status        = head.status;
    assign audio_format  = head.audio_format;
    assign channel_count = head.channel_count;
    assign rate_hz       = head.rate_hz;
    assign sample_bits   = head.sample_bits;
    assign last          = head.last;

endmodule
